@@ rtl/core/tsvc_pkg.sv @@
// Shared types and character constants for the TSV to CSV field escaper.
`timescale 1ns / 1ps

package tsvc_pkg;

    localparam int CODE_W = 21;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CH_TAB   = 21'h00009;
    localparam code_t CH_LF    = 21'h0000A;
    localparam code_t CH_CR    = 21'h0000D;
    localparam code_t CH_QUOTE = 21'h00022;
    localparam code_t CH_COMMA = 21'h0002C;

    // One classified input character as it travels from front to back.
    typedef struct packed {
        code_t code;
        logic  is_tab;
        logic  is_lf;
        logic  is_special;
    } token_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_OPEN  = 6'b000010,
        S_DATA  = 6'b000100,
        S_CLOSE = 6'b001000,
        S_DELIM = 6'b010000,
        S_LF    = 6'b100000
    } back_state_t;

endpackage

@@ rtl/core/tsvc_front.sv @@
// Front end: classifies input characters and queues them for the back end.
`timescale 1ns / 1ps

module tsvc_front
    import tsvc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  code_t  char_code,
    output logic   tok_valid,
    input  logic   tok_ready,
    output token_t tok
);

    localparam logic [1:0] Q_EMPTY = 2'd0;
    localparam logic [1:0] Q_FULL  = 2'd2;

    token_t     q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    token_t     in_tok;
    logic       push, pop;

    always_comb
    begin
        in_tok.code       = char_code;
        in_tok.is_tab     = (char_code == CH_TAB);
        in_tok.is_lf      = (char_code == CH_LF);
        in_tok.is_special = (char_code == CH_QUOTE) || (char_code == CH_COMMA)
                            || (char_code == CH_CR);
    end

    assign item_ready = (cnt_reg != Q_FULL);
    assign tok_valid  = (cnt_reg != Q_EMPTY);
    assign tok        = q_reg[rp_reg];
    assign push       = item_valid && item_ready;
    assign pop        = tok_valid && tok_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= Q_EMPTY;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_tok;
        end
    end

endmodule

@@ rtl/core/tsvc_back.sv @@
// Back end: field buffer, quoting sequencer and output register.
`timescale 1ns / 1ps

module tsvc_back
    import tsvc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   tok_valid,
    output logic   tok_ready,
    input  token_t tok,
    output logic   result_valid,
    input  logic   result_ready,
    output code_t  out_char,
    output logic   last_of_run
);

    localparam int IW   = $clog2(BUFFER_DEPTH);
    localparam int CNTW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(BUFFER_DEPTH);

    code_t           store_reg [BUFFER_DEPTH];
    logic [CNTW-1:0] fill_reg, fill_next;
    logic            nq_reg, nq_next;
    logic            fresh_reg, fresh_next;
    back_state_t     st_reg, st_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            dup_reg, dup_next;
    logic            qt_reg, qt_next;
    logic            closing_reg, closing_next;
    logic            lf_reg, lf_next;
    logic            ov_reg, ov_next;
    code_t           oc_reg, oc_next;
    logic            ol_reg, ol_next;

    logic            take;
    logic            out_free;
    logic            store_we;
    logic [CNTW-1:0] fill_inc;
    logic            idx_last;
    code_t           cur;
    logic            emit;
    code_t           emit_ch;
    logic            emit_last;

    assign tok_ready    = (st_reg == S_IDLE);
    assign take         = tok_valid && tok_ready;
    assign out_free     = !ov_reg || result_ready;
    assign fill_inc     = fill_reg + CNTW'(1);
    assign cur          = store_reg[idx_reg];
    assign idx_last     = ((CNTW'(idx_reg) + CNTW'(1)) == cnt_reg);
    assign result_valid = ov_reg;
    assign out_char     = oc_reg;
    assign last_of_run  = ol_reg;

    always_comb
    begin
        fill_next    = fill_reg;
        nq_next      = nq_reg;
        fresh_next   = fresh_reg;
        st_next      = st_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        dup_next     = dup_reg;
        qt_next      = qt_reg;
        closing_next = closing_reg;
        lf_next      = lf_reg;
        store_we     = 1'b0;
        emit         = 1'b0;
        emit_ch      = CH_QUOTE;
        emit_last    = 1'b0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    idx_next = '0;
                    dup_next = 1'b0;
                    if (tok.is_tab || tok.is_lf)
                    begin
                        qt_next      = nq_reg;
                        closing_next = 1'b1;
                        lf_next      = tok.is_lf;
                        cnt_next     = fill_reg;
                        if (nq_reg && fresh_reg)
                        begin
                            st_next = S_OPEN;
                        end
                        else if (fill_reg != '0)
                        begin
                            st_next = S_DATA;
                        end
                        else if (nq_reg)
                        begin
                            st_next = S_CLOSE;
                        end
                        else
                        begin
                            st_next = S_DELIM;
                        end
                        fill_next  = '0;
                        nq_next    = 1'b0;
                        fresh_next = 1'b1;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        if (fill_inc == DEPTH_C)
                        begin
                            // Buffer full: flush it as a quoted, still open field.
                            qt_next      = 1'b1;
                            closing_next = 1'b0;
                            lf_next      = 1'b0;
                            cnt_next     = DEPTH_C;
                            st_next      = fresh_reg ? S_OPEN : S_DATA;
                            fill_next    = '0;
                            nq_next      = 1'b1;
                            fresh_next   = 1'b0;
                        end
                        else
                        begin
                            fill_next = fill_inc;
                            nq_next   = nq_reg | tok.is_special;
                        end
                    end
                end
            end
            S_OPEN:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    emit_ch = CH_QUOTE;
                    st_next = (cnt_reg != '0) ? S_DATA : S_CLOSE;
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (qt_reg && (cur == CH_QUOTE) && !dup_reg)
                    begin
                        emit_ch  = CH_QUOTE;
                        dup_next = 1'b1;
                    end
                    else
                    begin
                        emit_ch  = cur;
                        dup_next = 1'b0;
                        idx_next = idx_reg + IW'(1);
                        if (idx_last)
                        begin
                            if (closing_reg)
                            begin
                                st_next = qt_reg ? S_CLOSE : S_DELIM;
                            end
                            else
                            begin
                                st_next   = S_IDLE;
                                emit_last = 1'b1;
                            end
                        end
                    end
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    emit_ch = CH_QUOTE;
                    st_next = S_DELIM;
                end
            end
            S_DELIM:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_ch   = lf_reg ? CH_CR : CH_COMMA;
                    emit_last = !lf_reg;
                    st_next   = lf_reg ? S_LF : S_IDLE;
                end
            end
            S_LF:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_ch   = CH_LF;
                    emit_last = 1'b1;
                    st_next   = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        ov_next = ov_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        if (out_free)
        begin
            ov_next = emit;
            oc_next = emit_ch;
            ol_next = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            nq_reg      <= 1'b0;
            fresh_reg   <= 1'b1;
            st_reg      <= S_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            dup_reg     <= 1'b0;
            qt_reg      <= 1'b0;
            closing_reg <= 1'b0;
            lf_reg      <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            nq_reg      <= nq_next;
            fresh_reg   <= fresh_next;
            st_reg      <= st_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            dup_reg     <= dup_next;
            qt_reg      <= qt_next;
            closing_reg <= closing_next;
            lf_reg      <= lf_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg <= oc_next;
        ol_reg <= ol_next;
        if (store_we)
        begin
            store_reg[fill_reg[IW-1:0]] <= tok.code;
        end
    end

endmodule

@@ rtl/core/tsv_to_csv_field_escaper_core.sv @@
// Top level of the TSV to CSV field escaper: front queue plus quoting back end.
`timescale 1ns / 1ps

// Converts a stream of code points from TSV to CSV, one character per input
// transfer and one per output transfer. Tab and newline end a field; the field
// then leaves as-is, or in double quotes with inner quotes doubled when it holds
// a quote, comma or CR, followed by a comma or CR LF. A field of BUFFER_DEPTH
// characters or more is sent in quoted pieces each time the buffer fills.
// last_of_run marks the final output character caused by one input character,
// and characters of an unterminated final field still held in the buffer are
// never sent. A two-entry queue takes input characters while the back end
// drains, so input is accepted every cycle until the queue fills. The back end
// stores an ordinary character in its buffer; on a delimiter or a full buffer
// it sends the field one output character at a time through the single output
// register that the quoting sequencer feeds, and takes no input until idle.
module tsv_to_csv_field_escaper_core
    import tsvc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  code_t char_code,
    output logic  result_valid,
    input  logic  result_ready,
    output code_t out_char,
    output logic  last_of_run
);

    logic   tok_valid;
    logic   tok_ready;
    token_t tok;

    tsvc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .char_code  (char_code),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok        (tok)
    );

    tsvc_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .tok          (tok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_char     (out_char),
        .last_of_run  (last_of_run)
    );

endmodule

@@ rtl/core/tsvc_checker.sv @@
// Port-level checks for the TSV to CSV field escaper, bound to the top level.
`timescale 1ns / 1ps

module tsvc_checker
    import tsvc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  item_valid,
    input logic  item_ready,
    input code_t char_code,
    input logic  result_valid,
    input logic  result_ready,
    input code_t out_char,
    input logic  last_of_run
);

    // An offered input character stays put until its transfer.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(char_code))
        else $error("waiting input changed");

    // A stalled result must hold its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(out_char) && $stable(last_of_run))
        else $error("stalled result changed");

    // A newline never appears inside a field, so it always closes the run.
    a_lf_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_char == CH_LF) |-> last_of_run)
        else $error("newline output without last_of_run");

    // Within one run the sequencer produces a character every cycle while the output is not stalled.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_of_run |=> result_valid)
        else $error("gap inside an output run");

endmodule

bind tsv_to_csv_field_escaper_core tsvc_checker u_tsvc_checker (.*);
